/* hw/rtl/kdef_pkg.sv */
package kdef_pkg;

  localparam int NUM_KEYS  = 2;
  localparam int TIME_BITS = 32;
  localparam int TICK_BITS = 16;
  localparam int NUM_REGS  = 3;

  // opcodes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_LONG    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_LONG_TICKS = 2'd0;
  localparam logic [1:0] REG_LONG_EN    = 2'd1;
  localparam logic [1:0] REG_LEVEL_MASK = 2'd2;

  typedef enum logic [1:0] {
    PH_POLL    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2
  } kdef_phase_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [NUM_KEYS-1:0]  key_levels;
    logic [TIME_BITS-1:0] now_time;
    logic                 key_select;
  } kdef_in_t;

  typedef struct packed {
    logic       event_key;
    logic [1:0] event_code;
  } kdef_out_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] long_ticks;
    logic                 long_en;
    logic [NUM_KEYS-1:0]  level_mask;
  } kdef_cfg_t;

  typedef struct packed {
    logic                 tick;
    logic                 rd;
    logic                 clr;
    logic                 pressed;
    logic [TIME_BITS-1:0] now_time;
  } kdef_key_cmd_t;

endpackage

/* hw/rtl/kdef_ram.sv */
module kdef_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/kdef_cfg.sv */
module kdef_cfg
  import kdef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output kdef_cfg_t   cfg
);

  kdef_cfg_t  cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx = paddr[3:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks <= TICK_BITS'(1000);
      cfg_r.long_en    <= 1'b1;
      cfg_r.level_mask <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_TICKS: cfg_r.long_ticks <= pwdata[TICK_BITS-1:0];
        REG_LONG_EN:    cfg_r.long_en    <= pwdata[0];
        REG_LEVEL_MASK: cfg_r.level_mask <= pwdata[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LONG_TICKS: prdata[TICK_BITS-1:0] = cfg_r.long_ticks;
      REG_LONG_EN:    prdata[0]             = cfg_r.long_en;
      REG_LEVEL_MASK: prdata[NUM_KEYS-1:0]  = cfg_r.level_mask;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/kdef_key.sv */
module kdef_key
  import kdef_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  kdef_cfg_t     cfg,
  input  kdef_key_cmd_t cmd,
  output logic          empty,
  output logic [1:0]    rd_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  kdef_phase_t          phase_r, phase_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;
  logic [PTR_W-1:0]     wr_slot_r, wr_slot_nxt;
  logic [PTR_W-1:0]     rd_slot_r, rd_slot_nxt;
  logic [TIME_BITS-1:0] held;
  logic                 push;
  logic [1:0]           push_code;
  logic                 pop;

  assign held  = cmd.now_time - hold_r;
  assign empty = (rd_slot_r == wr_slot_r);
  assign pop   = cmd.rd && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_POLL;
      hold_r    <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hold_r    <= hold_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    push      = 1'b0;
    push_code = EV_NONE;
    if (cmd.tick) begin
      unique case (phase_r)
        PH_CONFIRM: begin
          if (cmd.pressed) begin
            push      = 1'b1;
            push_code = EV_PRESS;
            phase_nxt = PH_HELD;
          end else begin
            phase_nxt = PH_POLL;
          end
        end
        PH_HELD: begin
          if (!cmd.pressed) begin
            push      = 1'b1;
            push_code = EV_RELEASE;
            phase_nxt = PH_POLL;
          end else if (cfg.long_en &&
                       held >= TIME_BITS'(cfg.long_ticks)) begin
            push      = 1'b1;
            push_code = EV_LONG;
            hold_nxt  = cmd.now_time;
          end
        end
        default: begin
          phase_nxt = PH_POLL;
          if (cmd.pressed) begin
            phase_nxt = PH_CONFIRM;
            hold_nxt  = cmd.now_time;
          end
        end
      endcase
    end
  end

  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    if (cmd.clr) begin
      wr_slot_nxt = '0;
      rd_slot_nxt = '0;
    end else begin
      if (push) begin
        wr_slot_nxt = (wr_slot_r == PTR_LAST) ? '0 : wr_slot_r + 1'b1;
      end
      if (pop) begin
        rd_slot_nxt = (rd_slot_r == PTR_LAST) ? '0 : rd_slot_r + 1'b1;
      end
    end
  end

  // reads and writes come from different items, so never in the same cycle
  kdef_ram #(
    .WIDTH (2),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_slot_r),
    .wdata (push_code),
    .re    (pop),
    .raddr (rd_slot_r),
    .rdata (rd_data)
  );

endmodule

/* hw/rtl/key_debounce_event_fifo.sv */
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  kdef_in_t  (opcode, levels, time, key)
// out_      output     out_valid/out_stall  kdef_out_t (event_key, event_code)
// cfg_      apb        psel/penable/pready  32-bit registers at 0x0, 0x4, 0x8
//
// one item per cycle while in_stall is low; a read result passes the read stage
// (event ram read) and then the output register
// ticks and clears give no result
// reset (synchronous, rst_n low) sets every key to poll and empties all fifos
// in_stall rises only when both the ram read stage and the output register
// hold results and the output side is stalled
module key_debounce_event_fifo
  import kdef_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  kdef_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kdef_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  kdef_cfg_t     cfg;
  kdef_key_cmd_t key_cmd   [NUM_KEYS];
  logic          key_empty [NUM_KEYS];
  logic [1:0]    key_rdata [NUM_KEYS];

  logic      accept;
  logic      is_tick, is_read, is_clear;
  logic      sel_empty;

  // read stage: holds the read while the ram data is registered
  logic      rs_valid_r, rs_valid_nxt;
  logic      rs_key_r;
  logic      rs_hit_r;
  logic      rs_move;

  // output register
  logic      out_valid_r, out_valid_nxt;
  kdef_out_t out_data_r;

  assign cfg_pready = 1'b1;

  kdef_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign rs_move  = rs_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = rs_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_tick  = accept && (in_data.opcode == OP_TICK);
  assign is_read  = accept && (in_data.opcode == OP_READ);
  assign is_clear = accept && (in_data.opcode == OP_CLEAR);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    always_comb begin
      key_cmd[k].tick     = is_tick;
      key_cmd[k].rd       = is_read && (in_data.key_select == 1'(k));
      key_cmd[k].clr      = is_clear && (in_data.key_select == 1'(k));
      // pressed when the raw level matches the key's mask bit
      key_cmd[k].pressed  = !(in_data.key_levels[k] ^ cfg.level_mask[k]);
      key_cmd[k].now_time = in_data.now_time;
    end

    kdef_key #(
      .FIFO_DEPTH (FIFO_DEPTH)
    ) u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg),
      .cmd     (key_cmd[k]),
      .empty   (key_empty[k]),
      .rd_data (key_rdata[k])
    );
  end

  assign sel_empty = key_empty[in_data.key_select];

  always_comb begin
    rs_valid_nxt = rs_valid_r;
    if (accept) begin
      rs_valid_nxt = is_read;
    end else if (rs_move) begin
      rs_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rs_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rs_valid_r  <= rs_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (is_read) begin
      rs_key_r <= in_data.key_select;
      rs_hit_r <= !sel_empty;
    end
    if (rs_move) begin
      out_data_r.event_key  <= rs_key_r;
      // an empty fifo reads as none; the ram holds its data while stalled
      out_data_r.event_code <= rs_hit_r ? key_rdata[rs_key_r] : EV_NONE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/kdef_chk.sv */
module kdef_chk
  import kdef_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input kdef_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input kdef_out_t out_data
);

  logic rd_acc;
  logic clr_acc;

  assign rd_acc  = in_valid && !in_stall && (in_data.opcode == OP_READ);
  assign clr_acc = in_valid && !in_stall && (in_data.opcode == OP_CLEAR);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // every accepted read is followed by a valid result
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |-> ##2 out_valid)
    else $error("read gave no result");

  // a read right after a clear of the same key returns none
  a_clear_read: assert property (@(posedge clk) disable iff (!rst_n)
    clr_acc ##1 (rd_acc && !out_valid &&
                 (in_data.key_select == $past(in_data.key_select)))
    |-> ##2 (out_valid && out_data.event_code == EV_NONE &&
             out_data.event_key == $past(in_data.key_select, 2)))
    else $error("read after clear not empty");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind key_debounce_event_fifo kdef_chk u_kdef_chk (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import kdef_pkg::*;

  // depth of each key's event ring, handed to the block as its parameter
  localparam int EVQ_DEPTH = 16;
  // opcode that the block ignores
  localparam logic [1:0] OP_SPARE = 2'd3;
  // watchdog, far above the slowest correct run
  localparam int CYCLE_LIMIT = 200000;

  // tracks key phases and event rings, and checks every returned event
  class key_event_tracker;
    logic [TICK_BITS-1:0] long_ticks;
    logic                 long_en;
    logic [NUM_KEYS-1:0]  level_mask;
    kdef_phase_t          phase [NUM_KEYS];
    logic [TIME_BITS-1:0] hold_start [NUM_KEYS];
    logic [1:0]           ring [NUM_KEYS][EVQ_DEPTH];
    int                   wr_ptr [NUM_KEYS];
    int                   rd_ptr [NUM_KEYS];
    kdef_out_t            queued_events [$];
    int                   errors;
    int                   items_seen;
    int                   code_hits [4];

    function new();
      long_ticks = 16'd1000;
      long_en    = 1'b1;
      level_mask = '0;
      errors     = 0;
      items_seen = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase[k]      = PH_POLL;
        hold_start[k] = '0;
        wr_ptr[k]     = 0;
        rd_ptr[k]     = 0;
        for (int i = 0; i < EVQ_DEPTH; i++) ring[k][i] = EV_NONE;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LONG_TICKS: long_ticks = val[TICK_BITS-1:0];
        REG_LONG_EN:    long_en = val[0];
        REG_LEVEL_MASK: level_mask = val[NUM_KEYS-1:0];
        default: ;
      endcase
    endfunction

    // no full check: a push always lands and may lap the reader
    function void push_event(int k, logic [1:0] code);
      ring[k][wr_ptr[k]] = code;
      wr_ptr[k] = (wr_ptr[k] + 1) % EVQ_DEPTH;
    endfunction

    function void tick_key(int k, logic [NUM_KEYS-1:0] levels, logic [TIME_BITS-1:0] now);
      logic                 pressed;
      logic [TIME_BITS-1:0] held_for;
      pressed  = (levels[k] == level_mask[k]);
      held_for = now - hold_start[k];
      case (phase[k])
        PH_CONFIRM: begin
          if (pressed) begin
            push_event(k, EV_PRESS);
            phase[k] = PH_HELD;
          end else begin
            phase[k] = PH_POLL;
          end
        end
        PH_HELD: begin
          if (!pressed) begin
            push_event(k, EV_RELEASE);
            phase[k] = PH_POLL;
          end else if (long_en && held_for >= TIME_BITS'(long_ticks)) begin
            push_event(k, EV_LONG);
            hold_start[k] = now;
          end
        end
        default: begin
          phase[k] = PH_POLL;
          if (pressed) begin
            phase[k]      = PH_CONFIRM;
            hold_start[k] = now;
          end
        end
      endcase
    endfunction

    function void note_item(kdef_in_t it);
      kdef_out_t res;
      int        k;
      items_seen++;
      k = it.key_select;
      case (it.opcode)
        OP_TICK: begin
          for (int i = 0; i < NUM_KEYS; i++) tick_key(i, it.key_levels, it.now_time);
        end
        OP_READ: begin
          res.event_key  = it.key_select;
          res.event_code = EV_NONE;
          if (rd_ptr[k] != wr_ptr[k]) begin
            res.event_code = ring[k][rd_ptr[k]];
            rd_ptr[k] = (rd_ptr[k] + 1) % EVQ_DEPTH;
          end
          queued_events.push_back(res);
        end
        OP_CLEAR: begin
          for (int i = 0; i < EVQ_DEPTH; i++) ring[k][i] = EV_NONE;
          wr_ptr[k] = 0;
          rd_ptr[k] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_event(kdef_out_t got);
      kdef_out_t want;
      if (queued_events.size() == 0) begin
        $error("event with none expected: key %0d code %0d", got.event_key, got.event_code);
        errors++;
        return;
      end
      want = queued_events.pop_front();
      code_hits[want.event_code]++;
      if (got.event_key !== want.event_key) begin
        $error("event_key mismatch: expected %0d, actual %0d", want.event_key, got.event_key);
        errors++;
      end
      if (got.event_code !== want.event_code) begin
        $error("event_code mismatch: expected %0d, actual %0d", want.event_code, got.event_code);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  kdef_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  kdef_out_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  key_event_tracker sb = new();

  // pacing knobs, in percent per cycle
  int send_idle_pct = 15;
  int stall_pct     = 15;
  // cycles left in a forced receiver hold-off
  int hold_off_left = 0;
  int cycle_count   = 0;
  int phases_run    = 0;

  // stimulus state: which keys the virtual finger holds, and the time count
  logic [NUM_KEYS-1:0]  key_down = '0;
  logic [TIME_BITS-1:0] now_t = '0;

  key_debounce_event_fifo #(
    .FIFO_DEPTH(EVQ_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // both handshakes are sampled here, before the block's own registers move
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_event(out_data);
    end
  end

  // receiver: random stalls, or a forced hold-off counted down here
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected",
               cycle_count, sb.queued_events.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // one register write: setup cycle, then access cycle until pready
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [15:0] ticks, logic en, logic [1:0] mask);
    cfg_write(REG_LONG_TICKS, {16'd0, ticks});
    cfg_write(REG_LONG_EN, {31'd0, en});
    cfg_write(REG_LEVEL_MASK, {30'd0, mask});
  endtask

  // offer one item, with random idle cycles ahead of it; returns at the
  // edge where it is taken
  task automatic send_op(logic [1:0] op, logic [1:0] levels, logic [31:0] t, logic key);
    kdef_in_t it;
    it.opcode     = op;
    it.key_levels = levels;
    it.now_time   = t;
    it.key_select = key;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, let every expected event come out, then cover the
  // pipe for ticks and clears still in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.queued_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed key activity: held keys with some contact bounce,
  // time running forward with rare jumps, reads and a few clears mixed in
  task automatic run_random(int n, int read_pct);
    int          done;
    int          r;
    logic [1:0]  lv;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < read_pct) begin
        send_op(OP_READ, 2'($urandom), $urandom, 1'($urandom_range(1)));
        done++;
      end else if (r < read_pct + 3) begin
        send_op(OP_CLEAR, 2'($urandom), $urandom, 1'($urandom_range(1)));
        done++;
      end else if (r < read_pct + 5) begin
        // ignored by the block, so not counted
        send_op(OP_SPARE, 2'($urandom), $urandom, 1'($urandom_range(1)));
      end else begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if ($urandom_range(99) < 20) key_down[k] = !key_down[k];
          lv[k] = key_down[k] ? sb.level_mask[k] : !sb.level_mask[k];
          // single-tick bounce
          if ($urandom_range(99) < 6) lv[k] = !lv[k];
        end
        if ($urandom_range(99) < 4) now_t = $urandom;
        else now_t += $urandom_range(1, 300);
        send_op(OP_TICK, lv, now_t, 1'($urandom_range(1)));
        done++;
      end
    end
  endtask

  initial begin
    logic [15:0] ticks;
    logic        en;
    logic [1:0]  mask;
    int          read_pct;
    int          count;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings: long press after 1000, pressed is level 0
    send_op(OP_TICK, 2'b11, 32'd0, 1'b0);
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);            // empty ring gives none
    send_op(OP_TICK, 2'b00, 32'd10, 1'b1);           // both keys start confirming
    send_op(OP_TICK, 2'b00, 32'd20, 1'b0);           // press confirmed on both
    send_op(OP_TICK, 2'b00, 32'd1010, 1'b0);         // held exactly the long time
    send_op(OP_TICK, 2'b01, 32'd1020, 1'b0);         // key 0 released
    send_op(OP_READ, 2'b11, 32'hFFFF_FFFF, 1'b0);
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);
    send_op(OP_TICK, 2'b11, 32'hFFFF_FC00, 1'b0);    // key 1 released
    send_op(OP_TICK, 2'b10, 32'hFFFF_FF00, 1'b0);
    send_op(OP_TICK, 2'b10, 32'hFFFF_FF10, 1'b0);
    send_op(OP_TICK, 2'b10, 32'h0000_02E8, 1'b0);    // long press across time wrap
    send_op(OP_SPARE, 2'b11, 32'hA5A5_5A5A, 1'b1);   // unused opcode
    send_op(OP_TICK, 2'b00, 32'h0000_02F0, 1'b1);
    send_op(OP_TICK, 2'b11, 32'h0000_0300, 1'b1);    // key 1 bounce rejected
    send_op(OP_READ, 2'b00, 32'd0, 1'b1);
    send_op(OP_CLEAR, 2'b00, 32'd0, 1'b1);
    send_op(OP_READ, 2'b00, 32'd0, 1'b1);            // none after clear
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);
    send_op(OP_CLEAR, 2'b00, 32'd0, 1'b0);
    send_op(OP_READ, 2'b00, 32'd0, 1'b0);
    settle();

    // random phases, each under its own register settings
    for (int ph = 0; ph < 7; ph++) begin
      send_idle_pct = 15;
      stall_pct     = 15;
      read_pct      = 30;
      count         = 120;
      case (ph)
        0: begin
          // long time zero fires every held tick; few reads, so rings lap
          ticks = 16'd0; en = 1'b1; mask = 2'b11; read_pct = 10; count = 140;
        end
        1: begin
          ticks = 16'hFFFF; en = 1'b1; mask = 2'b01;
          now_t = 32'hFFFF_F000;
        end
        2: begin
          ticks = 16'($urandom_range(1, 600)); en = 1'b0; mask = 2'b10;
        end
        3: begin
          // long stretch with no idling on either side
          ticks = 16'($urandom_range(100, 900)); en = 1'b1; mask = 2'b00;
          send_idle_pct = 0; stall_pct = 0; read_pct = 35; count = 160;
        end
        4: begin
          ticks = 16'd1; en = 1'b1; mask = 2'($urandom); read_pct = 60;
        end
        5: begin
          ticks = 16'($urandom_range(0, 400)); en = 1'b1; mask = 2'($urandom);
        end
        default: begin
          ticks = 16'd1000; en = 1'($urandom); mask = 2'($urandom); read_pct = 25;
        end
      endcase
      configure(ticks, en, mask);
      // read-heavy phase starts with the receiver holding off, so the
      // block fills and pushes back on its input
      if (ph == 4) hold_off_left = 300;
      run_random(count, read_pct);
      settle();
      phases_run++;
    end

    repeat (10) @(negedge clk);
    $display("covered %0d items over %0d register settings, %0d events checked",
             sb.items_seen, phases_run + 1,
             sb.code_hits[EV_NONE] + sb.code_hits[EV_PRESS] +
             sb.code_hits[EV_RELEASE] + sb.code_hits[EV_LONG]);
    $display("events: none %0d, press %0d, release %0d, long %0d",
             sb.code_hits[EV_NONE], sb.code_hits[EV_PRESS],
             sb.code_hits[EV_RELEASE], sb.code_hits[EV_LONG]);
    if (sb.errors == 0 && sb.queued_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/kdef_pkg.sv
hw/rtl/kdef_ram.sv
hw/rtl/kdef_cfg.sv
hw/rtl/kdef_key.sv
hw/rtl/key_debounce_event_fifo.sv
hw/rtl/kdef_chk.sv
verif/tb.sv
